### hdl/mlsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the Matroska lace size parser.
// No dependencies; imported by every module of the block.
package mlsp_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int PAY_W         = 32;
    localparam int ACC_W         = 49;
    localparam int AW            = 52;
    localparam int DIV_STEPS     = 32;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_BYTE  = 1'b1;

    localparam logic [1:0] LACE_NONE  = 2'd0;
    localparam logic [1:0] LACE_XIPH  = 2'd1;
    localparam logic [1:0] LACE_FIXED = 2'd2;
    localparam logic [1:0] LACE_EBML  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_VINT = 2'd1;
    localparam logic [1:0] ST_EXCEED   = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    localparam logic [7:0] XIPH_CONT = 8'hFF;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_COUNT  = 5'b00010,
        PH_XIPH   = 5'b00100,
        PH_VFIRST = 5'b01000,
        PH_VREST  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] size;
        logic [7:0]  rep;
        logic        last;
        logic [1:0]  status;
    } res_t;

    // signed vint delta bias: 2^(7*len-1) - 1
    function automatic logic [AW-1:0] vint_bias(input logic [2:0] len);
        logic [5:0] sh;
        sh = 6'(len) * 6'd7 - 6'd1;
        return (AW'(1) << sh) - AW'(1);
    endfunction

endpackage

### hdl/mlsp_alu.sv
`timescale 1ns / 1ps
// Shared add/subtract unit of the lace size parser.
// Depends on mlsp_pkg.
module mlsp_alu (
    input  logic [mlsp_pkg::AW-1:0] a,
    input  logic [mlsp_pkg::AW-1:0] b,
    input  logic                    sub,
    output logic [mlsp_pkg::AW-1:0] sum
);
    import mlsp_pkg::*;

    logic [AW-1:0] b_eff;

    assign b_eff = sub ? ~b : b;
    assign sum   = a + b_eff + AW'(sub);

endmodule

### hdl/mlsp_seq.sv
`timescale 1ns / 1ps
// Sequencer of the lace size parser: block state, division steps, result build.
// Depends on mlsp_pkg and mlsp_alu.
module mlsp_seq #(
    parameter int SIZE_BITS = mlsp_pkg::SIZE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_cmd,
    input  logic [31:0]       in_block_size,
    input  logic [1:0]        in_lacing,
    input  logic [7:0]        in_data_byte,
    input  logic              res_room,
    output logic              res_push,
    output mlsp_pkg::res_t    res
);
    import mlsp_pkg::*;

    localparam int            LIM_BITS = (SIZE_BITS >= 32) ? 32 : SIZE_BITS;
    localparam logic [AW-1:0] SIZE_LIM = (AW'(1) << LIM_BITS) - AW'(1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_START  = 15'b000000000000010,
        S_DEC    = 15'b000000000000100,
        S_COUNT  = 15'b000000000001000,
        S_DIV    = 15'b000000000010000,
        S_FIXREM = 15'b000000000100000,
        S_FIX2   = 15'b000000001000000,
        S_XIPH   = 15'b000000010000000,
        S_VFIRST = 15'b000000100000000,
        S_VREST  = 15'b000001000000000,
        S_V1     = 15'b000010000000000,
        S_V2     = 15'b000100000000000,
        S_FINISH = 15'b001000000000000,
        S_FINAL  = 15'b010000000000000,
        S_EMIT   = 15'b100000000000000
    } state_t;

    state_t               state_reg, state_next, enext_reg, enext_next;
    phase_t               phase_reg, phase_next;
    logic [1:0]           mode_reg, mode_next;
    logic [7:0]           ftg_reg, ftg_next, total_reg, total_next;
    logic [PAY_W-1:0]     pay_reg, pay_next, sum_reg, sum_next, prev_reg, prev_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [2:0]           vleft_reg, vleft_next, vlen_reg, vlen_next;
    logic [4:0]           cnt_reg, cnt_next;

    logic [31:0]          bs_reg, bs_next;
    logic [1:0]           lacing_reg, lacing_next;
    logic [7:0]           byte_reg, byte_next;
    logic [PAY_W-1:0]     q_reg, q_next, cur_reg, cur_next;
    logic [8:0]           r_reg, r_next;
    logic [AW-1:0]        tmp_reg, tmp_next;
    logic                 bad_reg, bad_next;
    res_t                 pend_reg, pend_next;

    logic [AW-1:0]        alu_a, alu_b, alu_sum;
    logic                 alu_sub;
    logic [7:0]           idx;
    logic                 neg, over;
    logic [9:0]           div_part;
    logic [8:0]           divisor;
    logic [2:0]           vlen_new;
    logic [7:0]           ftg_dec;

    mlsp_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign idx      = total_reg - ftg_reg;
    assign ftg_dec  = ftg_reg - 8'd1;
    assign neg      = alu_sum[AW-1];
    assign over     = |(alu_sum >> LIM_BITS);
    assign div_part = {r_reg, q_reg[PAY_W-1]};
    assign divisor  = {1'b0, total_reg} + 9'd1;
    assign in_ready = (state_reg == S_IDLE);
    assign res_push = (state_reg == S_EMIT) && res_room;
    assign res      = pend_reg;

    always_comb
    begin
        if (byte_reg[7])      vlen_new = 3'd1;
        else if (byte_reg[6]) vlen_new = 3'd2;
        else if (byte_reg[5]) vlen_new = 3'd3;
        else if (byte_reg[4]) vlen_new = 3'd4;
        else if (byte_reg[3]) vlen_new = 3'd5;
        else if (byte_reg[2]) vlen_new = 3'd6;
        else                  vlen_new = 3'd7;
    end

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_START:
            begin
                alu_a   = AW'(bs_reg);
                alu_b   = AW'(4);
                alu_sub = 1'b1;
            end
            S_DEC:
            begin
                alu_a   = AW'(pay_reg);
                alu_b   = AW'(1);
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = AW'(div_part);
                alu_b   = AW'(divisor);
                alu_sub = 1'b1;
            end
            S_FIXREM:
            begin
                alu_a = AW'(q_reg);
                alu_b = AW'(r_reg);
            end
            S_XIPH:
            begin
                alu_a = AW'(acc_reg);
                alu_b = AW'(byte_reg);
            end
            S_V1:
            begin
                alu_a   = AW'(acc_reg);
                alu_b   = (idx == 8'd0) ? '0 : vint_bias(vlen_reg);
                alu_sub = 1'b1;
            end
            S_V2:
            begin
                alu_a = tmp_reg;
                alu_b = (idx == 8'd0) ? '0 : AW'(prev_reg);
            end
            S_FINISH:
            begin
                alu_a = AW'(sum_reg);
                alu_b = AW'(cur_reg);
            end
            S_FINAL:
            begin
                alu_a   = AW'(pay_reg);
                alu_b   = AW'(sum_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        enext_next  = enext_reg;
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        ftg_next    = ftg_reg;
        total_next  = total_reg;
        pay_next    = pay_reg;
        sum_next    = sum_reg;
        prev_next   = prev_reg;
        acc_next    = acc_reg;
        vleft_next  = vleft_reg;
        vlen_next   = vlen_reg;
        cnt_next    = cnt_reg;
        bs_next     = bs_reg;
        lacing_next = lacing_reg;
        byte_next   = byte_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        tmp_next    = tmp_reg;
        cur_next    = cur_reg;
        bad_next    = bad_reg;
        pend_next   = pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    bs_next     = in_block_size;
                    lacing_next = in_lacing;
                    byte_next   = in_data_byte;
                    if (in_cmd == CMD_START)
                        state_next = S_START;
                    else if (phase_reg == PH_IDLE)
                        state_next = S_IDLE;
                    else if (pay_reg == '0)
                    begin
                        pend_next  = '{idx: idx, size: '0, rep: 8'd1, last: 1'b1,
                                       status: ST_EXCEED};
                        phase_next = PH_IDLE;
                        enext_next = S_IDLE;
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_DEC;
                end
            end
            S_START:
            begin
                mode_next  = lacing_reg;
                ftg_next   = '0;
                total_next = '0;
                sum_next   = '0;
                prev_next  = '0;
                acc_next   = '0;
                vleft_next = '0;
                vlen_next  = '0;
                phase_next = PH_IDLE;
                enext_next = S_IDLE;
                if (neg)
                begin
                    pay_next   = '0;
                    pend_next  = '{idx: '0, size: '0, rep: 8'd1, last: 1'b1,
                                   status: ST_SHORT};
                    state_next = S_EMIT;
                end
                else
                begin
                    pay_next = alu_sum[PAY_W-1:0];
                    if (lacing_reg == LACE_NONE)
                    begin
                        pend_next  = '{idx: '0, size: alu_sum[31:0], rep: 8'd1,
                                       last: 1'b1, status: ST_OK};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DEC:
            begin
                pay_next = alu_sum[PAY_W-1:0];
                unique case (phase_reg)
                    PH_COUNT:  state_next = S_COUNT;
                    PH_XIPH:   state_next = S_XIPH;
                    PH_VFIRST: state_next = S_VFIRST;
                    PH_VREST:  state_next = S_VREST;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_COUNT:
            begin
                total_next = byte_reg;
                ftg_next   = byte_reg;
                sum_next   = '0;
                prev_next  = '0;
                acc_next   = '0;
                if (byte_reg == 8'd0)
                    state_next = S_FINAL;
                else if (mode_reg == LACE_FIXED)
                begin
                    q_next     = pay_reg;
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    phase_next = (mode_reg == LACE_XIPH) ? PH_XIPH : PH_VFIRST;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                r_next   = neg ? div_part[8:0] : alu_sum[8:0];
                q_next   = {q_reg[PAY_W-2:0], ~neg};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = S_FIXREM;
            end
            S_FIXREM:
            begin
                // last frame = payload - q*(n-1) = q + r, with n = total_reg + 1 frames
                cur_next   = alu_sum[PAY_W-1:0];
                pend_next  = '{idx: '0, size: q_reg, rep: total_reg, last: 1'b0,
                               status: ST_OK};
                enext_next = S_FIX2;
                state_next = S_EMIT;
            end
            S_FIX2:
            begin
                pend_next  = '{idx: total_reg, size: cur_reg, rep: 8'd1, last: 1'b1,
                               status: ST_OK};
                phase_next = PH_IDLE;
                enext_next = S_IDLE;
                state_next = S_EMIT;
            end
            S_XIPH:
            begin
                if (over)
                    acc_next = SIZE_LIM[ACC_W-1:0];
                else
                    acc_next = alu_sum[ACC_W-1:0];
                if (byte_reg == XIPH_CONT && pay_reg != '0)
                    state_next = S_IDLE;
                else
                begin
                    cur_next   = over ? SIZE_LIM[PAY_W-1:0] : alu_sum[PAY_W-1:0];
                    bad_next   = 1'b0;
                    acc_next   = '0;
                    state_next = S_FINISH;
                end
            end
            S_VFIRST:
            begin
                if (byte_reg < 8'd2)
                begin
                    pend_next  = '{idx: idx, size: '0, rep: 8'd1, last: 1'b1,
                                   status: ST_BAD_VINT};
                    phase_next = PH_IDLE;
                    enext_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    acc_next   = ACC_W'(byte_reg & (8'hFF >> vlen_new));
                    vlen_next  = vlen_new;
                    vleft_next = vlen_new - 3'd1;
                    if (vlen_new == 3'd1)
                        state_next = S_V1;
                    else
                    begin
                        phase_next = PH_VREST;
                        state_next = S_IDLE;
                    end
                end
            end
            S_VREST:
            begin
                acc_next   = {acc_reg[ACC_W-9:0], byte_reg};
                vleft_next = vleft_reg - 3'd1;
                state_next = (vleft_reg == 3'd1) ? S_V1 : S_IDLE;
            end
            S_V1:
            begin
                tmp_next   = alu_sum;
                state_next = S_V2;
            end
            S_V2:
            begin
                if (neg)
                begin
                    cur_next = '0;
                    bad_next = 1'b1;
                end
                else if (over)
                begin
                    cur_next = SIZE_LIM[PAY_W-1:0];
                    bad_next = 1'b1;
                end
                else
                begin
                    cur_next = alu_sum[PAY_W-1:0];
                    bad_next = 1'b0;
                end
                acc_next   = '0;
                phase_next = PH_VFIRST;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                pend_next = '{idx: idx, size: cur_reg, rep: 8'd1, last: 1'b0,
                              status: ST_OK};
                if (bad_reg || alu_sum[PAY_W])
                    sum_next = '1;
                else
                    sum_next = alu_sum[PAY_W-1:0];
                prev_next  = cur_reg;
                ftg_next   = ftg_dec;
                enext_next = (ftg_dec == 8'd0) ? S_FINAL : S_IDLE;
                state_next = S_EMIT;
            end
            S_FINAL:
            begin
                if (neg)
                    pend_next = '{idx: total_reg, size: '0, rep: 8'd1, last: 1'b1,
                                  status: ST_EXCEED};
                else
                    pend_next = '{idx: total_reg, size: alu_sum[31:0], rep: 8'd1,
                                  last: 1'b1, status: ST_OK};
                phase_next = PH_IDLE;
                enext_next = S_IDLE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_room)
                    state_next = enext_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            enext_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            mode_reg  <= '0;
            ftg_reg   <= '0;
            total_reg <= '0;
            pay_reg   <= '0;
            sum_reg   <= '0;
            prev_reg  <= '0;
            acc_reg   <= '0;
            vleft_reg <= '0;
            vlen_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            enext_reg <= enext_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            ftg_reg   <= ftg_next;
            total_reg <= total_next;
            pay_reg   <= pay_next;
            sum_reg   <= sum_next;
            prev_reg  <= prev_next;
            acc_reg   <= acc_next;
            vleft_reg <= vleft_next;
            vlen_reg  <= vlen_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bs_reg     <= bs_next;
        lacing_reg <= lacing_next;
        byte_reg   <= byte_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        tmp_reg    <= tmp_next;
        cur_reg    <= cur_next;
        bad_reg    <= bad_next;
        pend_reg   <= pend_next;
    end

endmodule

### hdl/mkv_lace_size_parser_top.sv
`timescale 1ns / 1ps
// Top level of the Matroska SimpleBlock lace size parser: streaming ports, result queue.
// Depends on mlsp_pkg, mlsp_seq (with mlsp_alu).
//
// One item at a time; a new item is taken only in the idle state. A start item opens a
// block. A lace header byte with no block open is dropped; others move the header state
// on, close a Xiph or EBML frame (and the block, after its last frame), or give a result
// such as a bad vint length, a zero count or a used-up payload. The count byte of fixed
// lacing runs the 32 restoring division steps through the one shared 52-bit adder that
// carries the size sums, differences and compares. Results wait in a two-entry output
// queue, so the sequencer stalls only when two results are still untaken.
module mkv_lace_size_parser_top #(
    parameter int SIZE_BITS = mlsp_pkg::SIZE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // block_size[31:0], lacing[33:32], data_byte[41:34]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // frame_index[7:0], frame_size[39:8], repeat_count[47:40]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);
    import mlsp_pkg::*;

    res_t       qbuf_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop, room;
    res_t       res, head;

    mlsp_seq #(
        .SIZE_BITS (SIZE_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (s_tuser[0]),
        .in_block_size (s_tdata[31:0]),
        .in_lacing     (s_tdata[33:32]),
        .in_data_byte  (s_tdata[41:34]),
        .res_room      (room),
        .res_push      (push),
        .res           (res)
    );

    assign room     = (cnt_reg != 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = qbuf_reg[rp_reg];
    assign m_tdata  = {head.rep, head.size, head.idx};
    assign m_tuser  = head.status;
    assign m_tlast  = head.last;

    assign wp_next  = push ? ~wp_reg : wp_reg;
    assign rp_next  = pop ? ~rp_reg : rp_reg;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            qbuf_reg[wp_reg] <= res;
    end

endmodule

### hdl/mlsp_chk.sv
`timescale 1ns / 1ps
// Port-level checks on the lace size parser, bound to the top level.
// Depends on mlsp_pkg and mkv_lace_size_parser_top.
module mlsp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import mlsp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |->
            m_tlast && m_tdata[39:8] == 32'd0 && m_tdata[47:40] == 8'd1)
        else $error("error result not closing with zero size");

    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:40] != 8'd0)
        else $error("zero repeat count");

    a_short_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_SHORT |-> m_tdata[7:0] == 8'd0)
        else $error("short block with nonzero frame index");

endmodule

bind mkv_lace_size_parser_top mlsp_chk u_mlsp_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
